>>> src/rrc_pkg.sv
// Package for the rectangle raster canvas: item structs, operation and status codes,
// register indexes and reset values. No dependencies.
package rrc_pkg;

   localparam int COORD_W = 24;
   localparam int CALC_W = 26;
   localparam int UNIT = 256;
   localparam int FRAC_W = 8;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W = 9;

   localparam logic [1:0] OP_CLEAR = 2'd0;
   localparam logic [1:0] OP_DRAW = 2'd1;
   localparam logic [1:0] OP_READ = 2'd2;

   localparam logic [1:0] STATUS_OK = 2'd0;
   localparam logic [1:0] STATUS_BAD_SIZE = 2'd1;
   localparam logic [1:0] STATUS_OUT_OF_RANGE = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_CANVAS_WIDTH = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CANVAS_HEIGHT = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BACKGROUND_CHAR = 2'd2;

   localparam logic [8:0] CANVAS_WIDTH_RESET = 9'd1;
   localparam logic [8:0] CANVAS_HEIGHT_RESET = 9'd1;
   localparam logic [7:0] BACKGROUND_CHAR_RESET = 8'd32;

   typedef struct packed {
      logic [1:0] operation;
      logic filled;
      logic signed [COORD_W-1:0] left_x;
      logic signed [COORD_W-1:0] top_y;
      logic signed [COORD_W-1:0] span_x;
      logic signed [COORD_W-1:0] span_y;
      logic [7:0] paint_char;
      logic [7:0] read_row;
      logic [7:0] read_col;
   } req_payload_type;

   typedef struct packed {
      logic [1:0] status;
      logic [7:0] cell_char;
   } rsp_payload_type;

   typedef struct packed {
      logic enable;
      logic write;
   } mem_ctl_type;

endpackage

>>> src/rrc_canvas_mem.sv
// Canvas cell memory: one port, synchronous write, registered read data.
// Depends on rrc_pkg for the port control struct.
module rrc_canvas_mem #(
   parameter int DEPTH = 65536,
   parameter int ADDR_W = 16
) (
   input  logic clock,
   input  rrc_pkg::mem_ctl_type mem_ctl,
   input  logic [ADDR_W-1:0] mem_addr,
   input  logic [7:0] mem_wdata,
   output logic [7:0] mem_rdata
);
   import rrc_pkg::*;

   logic [7:0] canvas_ram [DEPTH];
   logic [7:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (mem_ctl.enable) begin
         if (mem_ctl.write) begin
            canvas_ram[mem_addr] <= mem_wdata;
         end else begin
            rdata_ff <= canvas_ram[mem_addr];
         end
      end
   end

   assign mem_rdata = rdata_ff;

endmodule

>>> src/rrc_engine.sv
// Item sequencer: decodes an item, sweeps the canvas for clear and draw, tests each
// pixel centre against the rectangle and drives the canvas memory. Depends on rrc_pkg.
module rrc_engine #(
   parameter int MAX_SIDE = 256,
   parameter int IDX_W = 8,
   parameter int CNT_W = 9,
   parameter int ADDR_W = 16
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  rrc_pkg::req_payload_type req_payload,
   input  logic [8:0] cfg_width,
   input  logic [8:0] cfg_height,
   input  logic [7:0] cfg_background,
   output logic res_valid,
   input  logic res_ready,
   output rrc_pkg::rsp_payload_type res_payload,
   output rrc_pkg::mem_ctl_type mem_ctl,
   output logic [ADDR_W-1:0] mem_addr,
   output logic [7:0] mem_wdata,
   input  logic [7:0] mem_rdata
);
   import rrc_pkg::*;

   localparam int SW = (CNT_W > 9) ? CNT_W : 9;
   localparam int RW = (CNT_W > 8) ? CNT_W : 8;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_PREP = 3'd1;
   localparam logic [2:0] S_SWEEP = 3'd2;
   localparam logic [2:0] S_RDWAIT = 3'd3;
   localparam logic [2:0] S_DONE = 3'd4;

   logic [2:0] state_ff, state_in;
   logic [1:0] op_ff, op_in;
   logic fill_ff, fill_in;
   logic signed [COORD_W-1:0] x0_ff, x0_in, y0_ff, y0_in, sx_ff, sx_in, sy_ff, sy_in;
   logic [7:0] paint_ff, paint_in, rrow_ff, rrow_in, rcol_ff, rcol_in;
   logic signed [CALC_W-1:0] x1_ff, x1_in, y1_ff, y1_in;
   logic signed [CALC_W-1:0] x0p_ff, x0p_in, y0p_ff, y0p_in;
   logic signed [CALC_W-1:0] x1m_ff, x1m_in, y1m_ff, y1m_in;
   logic [IDX_W-1:0] col_ff, col_in, row_ff, row_in;
   logic [1:0] status_ff, status_in;
   logic [7:0] cell_ff, cell_in;

   logic [CNT_W-1:0] w_use, h_use;
   logic signed [CALC_W-1:0] px, py;
   logic in_x, in_y, near_edge, hit, col_last, row_last, read_out;
   logic [IDX_W-1:0] addr_row, addr_col;

   always_comb begin
      if (cfg_width == 9'd0) begin
         w_use = CNT_W'(1);
      end else if (SW'(cfg_width) > SW'(MAX_SIDE)) begin
         w_use = CNT_W'(MAX_SIDE);
      end else begin
         w_use = CNT_W'(cfg_width);
      end
      if (cfg_height == 9'd0) begin
         h_use = CNT_W'(1);
      end else if (SW'(cfg_height) > SW'(MAX_SIDE)) begin
         h_use = CNT_W'(MAX_SIDE);
      end else begin
         h_use = CNT_W'(cfg_height);
      end
   end

   assign px = CALC_W'({col_ff, {FRAC_W{1'b0}}});
   assign py = CALC_W'({row_ff, {FRAC_W{1'b0}}});
   assign in_x = (px >= CALC_W'(x0_ff)) && (px <= x1_ff);
   assign in_y = (py >= CALC_W'(y0_ff)) && (py <= y1_ff);
   assign near_edge = (px < x0p_ff) || (px > x1m_ff) || (py < y0p_ff) || (py > y1m_ff);
   assign hit = (op_ff == OP_CLEAR) || (in_x && in_y && (fill_ff || near_edge));
   assign col_last = (CNT_W'(col_ff) == w_use - CNT_W'(1));
   assign row_last = (CNT_W'(row_ff) == h_use - CNT_W'(1));
   assign read_out = (RW'(rrow_ff) >= RW'(h_use)) || (RW'(rcol_ff) >= RW'(w_use));

   assign addr_row = (state_ff == S_SWEEP) ? row_ff : IDX_W'(rrow_ff);
   assign addr_col = (state_ff == S_SWEEP) ? col_ff : IDX_W'(rcol_ff);
   assign mem_addr = ADDR_W'(addr_row) * ADDR_W'(MAX_SIDE) + ADDR_W'(addr_col);
   assign mem_wdata = (op_ff == OP_CLEAR) ? cfg_background : paint_ff;

   always_comb begin
      state_in = state_ff;
      op_in = op_ff;
      fill_in = fill_ff;
      x0_in = x0_ff;
      y0_in = y0_ff;
      sx_in = sx_ff;
      sy_in = sy_ff;
      paint_in = paint_ff;
      rrow_in = rrow_ff;
      rcol_in = rcol_ff;
      x1_in = x1_ff;
      y1_in = y1_ff;
      x0p_in = x0p_ff;
      y0p_in = y0p_ff;
      x1m_in = x1m_ff;
      y1m_in = y1m_ff;
      col_in = col_ff;
      row_in = row_ff;
      status_in = status_ff;
      cell_in = cell_ff;
      mem_ctl = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in = req_payload.operation;
               fill_in = req_payload.filled;
               x0_in = req_payload.left_x;
               y0_in = req_payload.top_y;
               sx_in = req_payload.span_x;
               sy_in = req_payload.span_y;
               paint_in = req_payload.paint_char;
               rrow_in = req_payload.read_row;
               rcol_in = req_payload.read_col;
               state_in = S_PREP;
            end
         end
         S_PREP: begin
            x1_in = CALC_W'(x0_ff) + CALC_W'(sx_ff);
            y1_in = CALC_W'(y0_ff) + CALC_W'(sy_ff);
            x0p_in = CALC_W'(x0_ff) + CALC_W'(UNIT);
            y0p_in = CALC_W'(y0_ff) + CALC_W'(UNIT);
            x1m_in = CALC_W'(x0_ff) + CALC_W'(sx_ff) - CALC_W'(UNIT);
            y1m_in = CALC_W'(y0_ff) + CALC_W'(sy_ff) - CALC_W'(UNIT);
            col_in = '0;
            row_in = '0;
            status_in = STATUS_OK;
            cell_in = 8'd0;
            unique case (op_ff)
               OP_CLEAR: begin
                  state_in = S_SWEEP;
               end
               OP_DRAW: begin
                  if (sx_ff[COORD_W-1] || sx_ff == '0 || sy_ff[COORD_W-1] || sy_ff == '0) begin
                     status_in = STATUS_BAD_SIZE;
                     state_in = S_DONE;
                  end else begin
                     state_in = S_SWEEP;
                  end
               end
               OP_READ: begin
                  if (read_out) begin
                     status_in = STATUS_OUT_OF_RANGE;
                     state_in = S_DONE;
                  end else begin
                     mem_ctl.enable = 1'b1;
                     state_in = S_RDWAIT;
                  end
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end
         S_SWEEP: begin
            mem_ctl.enable = hit;
            mem_ctl.write = 1'b1;
            if (col_last) begin
               col_in = '0;
               if (row_last) begin
                  state_in = S_DONE;
               end else begin
                  row_in = row_ff + IDX_W'(1);
               end
            end else begin
               col_in = col_ff + IDX_W'(1);
            end
         end
         S_RDWAIT: begin
            cell_in = mem_rdata;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      op_ff <= op_in;
      fill_ff <= fill_in;
      x0_ff <= x0_in;
      y0_ff <= y0_in;
      sx_ff <= sx_in;
      sy_ff <= sy_in;
      paint_ff <= paint_in;
      rrow_ff <= rrow_in;
      rcol_ff <= rcol_in;
      x1_ff <= x1_in;
      y1_ff <= y1_in;
      x0p_ff <= x0p_in;
      y0p_ff <= y0p_in;
      x1m_ff <= x1m_in;
      y1m_ff <= y1m_in;
      col_ff <= col_in;
      row_ff <= row_in;
      status_ff <= status_in;
      cell_ff <= cell_in;
   end

   assign req_stall = (state_ff != S_IDLE);
   assign res_valid = (state_ff == S_DONE);
   assign res_payload.status = status_ff;
   assign res_payload.cell_char = cell_ff;

endmodule

>>> src/rectangle_raster_canvas_top.sv
// Rectangle raster canvas: a character canvas of up to MAX_SIDE x MAX_SIDE byte cells
// in one single-port memory. Every item gives one result. A clear or a valid draw
// sweeps the cells in use one per cycle, passing the prepare, sweep and done states
// before its result enters the output register. A draw with a non-positive size, a
// read outside the canvas and the unused operation go from prepare straight to done,
// a read inside the canvas through a read-wait state. The next item is taken once the
// result has entered the output register and the block is idle again. The single
// memory port, written at most once per cell, sets the sweep time. One item is worked
// at a time; a finished result waits in the output register while the next item is
// taken. Cells hold no defined value until a clear or draw writes them. Configuration
// registers are to be written while the block is idle; the block does not enforce it.
// Depends on rrc_pkg, rrc_engine and rrc_canvas_mem.
module rectangle_raster_canvas_top #(
   parameter int MAX_SIDE = 256
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  rrc_pkg::req_payload_type req_payload,
   output logic rsp_valid,
   input  logic rsp_stall,
   output rrc_pkg::rsp_payload_type rsp_payload,
   input  logic csr_we,
   input  logic [rrc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [rrc_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import rrc_pkg::*;

   localparam int IDX_W = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
   localparam int CNT_W = $clog2(MAX_SIDE + 1);
   localparam int DEPTH = MAX_SIDE * MAX_SIDE;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [8:0] width_ff, height_ff;
   logic [7:0] background_ff;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_payload_ff, rsp_payload_in;

   logic res_valid, res_ready;
   rsp_payload_type res_payload;
   mem_ctl_type mem_ctl;
   logic [ADDR_W-1:0] mem_addr;
   logic [7:0] mem_wdata, mem_rdata;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= CANVAS_WIDTH_RESET;
         height_ff <= CANVAS_HEIGHT_RESET;
         background_ff <= BACKGROUND_CHAR_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_CANVAS_WIDTH: width_ff <= csr_wdata;
            CSR_CANVAS_HEIGHT: height_ff <= csr_wdata;
            CSR_BACKGROUND_CHAR: background_ff <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   rrc_engine #(
      .MAX_SIDE(MAX_SIDE),
      .IDX_W(IDX_W),
      .CNT_W(CNT_W),
      .ADDR_W(ADDR_W)
   ) u_engine (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_payload(req_payload),
      .cfg_width(width_ff),
      .cfg_height(height_ff),
      .cfg_background(background_ff),
      .res_valid(res_valid),
      .res_ready(res_ready),
      .res_payload(res_payload),
      .mem_ctl(mem_ctl),
      .mem_addr(mem_addr),
      .mem_wdata(mem_wdata),
      .mem_rdata(mem_rdata)
   );

   rrc_canvas_mem #(
      .DEPTH(DEPTH),
      .ADDR_W(ADDR_W)
   ) u_mem (
      .clock(clock),
      .mem_ctl(mem_ctl),
      .mem_addr(mem_addr),
      .mem_wdata(mem_wdata),
      .mem_rdata(mem_rdata)
   );

   assign res_ready = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_payload_in = rsp_payload_ff;
      if (res_valid && res_ready) begin
         rsp_valid_in = 1'b1;
         rsp_payload_in = res_payload;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

>>> src/rrc_checker.sv
// Port-level checks for the rectangle raster canvas and the bind that attaches them.
// Depends on rrc_pkg and rectangle_raster_canvas_top.
module rrc_checker (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   input  logic req_stall,
   input  logic rsp_valid,
   input  logic rsp_stall,
   input  rrc_pkg::rsp_payload_type rsp_payload
);
   import rrc_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("result item changed while stalled");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second item taken while one is at work");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.status == STATUS_OK
         || rsp_payload.status == STATUS_BAD_SIZE
         || rsp_payload.status == STATUS_OUT_OF_RANGE))
      else $error("unknown status code");

   a_error_no_char: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.status != STATUS_OK |-> rsp_payload.cell_char == 8'd0)
      else $error("error result carries a cell byte");

endmodule

bind rectangle_raster_canvas_top rrc_checker u_checker (
   .clock(clock),
   .reset(reset),
   .req_valid(req_valid),
   .req_stall(req_stall),
   .rsp_valid(rsp_valid),
   .rsp_stall(rsp_stall),
   .rsp_payload(rsp_payload)
);
